// ----- design/odwr_pkg.sv -----
// ----------------------------------------------------------------------------
// Odometry wrap tracker package
// Shared types, status codes and register indexes.
// ----------------------------------------------------------------------------
package odwr_pkg;

  localparam int unsigned CoordW   = 20;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WRAP      = 3'd1,
    ST_REBOOT    = 3'd2,
    ST_CRASH     = 3'd3,
    ST_UNCERTAIN = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COORD_RANGE  = 3'd0,
    REG_COORD_THR    = 3'd1,
    REG_ANGLE_RANGE  = 3'd2,
    REG_ANGLE_THR    = 3'd3,
    REG_SUSPEND_PER  = 3'd4
  } reg_idx_e;

  localparam logic [CoordW-1:0]  CoordRangeRst = 20'd32000;
  localparam logic [CoordW-1:0]  CoordThrRst   = 20'd1000;
  localparam logic [CoordW-1:0]  AngleRangeRst = 20'd31415;
  localparam logic [CoordW-1:0]  AngleThrRst   = 20'd785;
  localparam logic [PeriodW-1:0] SuspendPerRst = 32'd1000;

  typedef struct packed {
    logic               command;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_angle;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic               valid_res;
    status_e            x_status;
    status_e            y_status;
    status_e            angle_status;
    logic               motion_suspended;
  } out_item_t;

  // What one axis lane reports to the merge logic
  typedef struct packed {
    status_e     status;
    logic        brk;
    logic [31:0] off;
    logic [31:0] track;
  } lane_res_t;

endpackage

// ----- design/odwr_lane.sv -----
// ----------------------------------------------------------------------------
// Odometry axis lane
// Classifies one axis jump and produces the new offset and tracked value.
// ----------------------------------------------------------------------------
module odwr_lane (
  input  logic signed [15:0]          raw_i,
  input  logic [31:0]                 off_i,
  input  logic [31:0]                 last_i,
  input  logic [odwr_pkg::CoordW-1:0] range_i,
  input  logic [odwr_pkg::CoordW-1:0] thr_i,
  output odwr_pkg::lane_res_t         res_o
);

  logic [31:0] raw_w;
  logic [31:0] sum;
  logic [31:0] diff;
  logic [31:0] mag;
  logic [31:0] cur;
  logic [31:0] cur_mag;
  logic [31:0] step;
  logic [21:0] hi;
  logic [21:0] lo;
  logic [16:0] raw17;
  logic [16:0] raw_mag;
  logic [31:0] thr_w;
  logic        big;
  logic        in_band;

  assign raw_w   = {{16{raw_i[15]}}, raw_i};
  assign sum     = raw_w + off_i;
  assign diff    = sum - last_i;
  assign mag     = diff[31] ? (32'd0 - diff) : diff;
  assign cur     = last_i + off_i;
  assign cur_mag = cur[31] ? (32'd0 - cur) : cur;
  assign step    = {11'd0, range_i, 1'b0};
  assign thr_w   = {12'd0, thr_i};
  // lo goes negative when the threshold exceeds twice the range: bound always met
  assign hi      = {1'b0, range_i, 1'b0} + {2'b00, thr_i};
  assign lo      = {1'b0, range_i, 1'b0} - {2'b00, thr_i};
  assign raw17   = {raw_i[15], raw_i};
  assign raw_mag = raw17[16] ? (17'd0 - raw17) : raw17;

  assign big     = mag > thr_w;
  assign in_band = (mag <= {10'd0, hi}) && (lo[21] || (mag >= {10'd0, lo}));

  always_comb begin
    res_o.brk    = 1'b0;
    res_o.off    = off_i;
    res_o.track  = sum;
    res_o.status = odwr_pkg::ST_OK;
    if (big) begin
      if (in_band) begin
        res_o.status = odwr_pkg::ST_WRAP;
        res_o.off    = diff[31] ? (off_i + step) : (off_i - step);
        res_o.track  = diff[31] ? (sum + step) : (sum - step);
      end else begin
        // re-base: raw + (last - raw) lands on last
        res_o.brk    = 1'b1;
        res_o.off    = last_i - raw_w;
        res_o.track  = last_i;
        res_o.status = ({3'd0, raw_mag} <= thr_i) ? odwr_pkg::ST_REBOOT
                                                   : odwr_pkg::ST_CRASH;
      end
    end else if (cur_mag < thr_w) begin
      res_o.status = odwr_pkg::ST_UNCERTAIN;
    end
  end

endmodule

// ----- design/odometry_wrap_reboot_tracker.sv -----
// ----------------------------------------------------------------------------
// Odometry wrap and reboot tracker
// Unwraps x, y and heading readings and flags reboots, crashes and suspends.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while the input is ready; its result is
// registered into the output register or, while a result waits, into the
// skid slot. Three combinational axis lanes (x, y, heading) run side by
// side, each classifying its jump as ok, wrap, reboot, crash or uncertain
// and proposing a new offset and tracked value; the merge logic here combines
// their verdicts with the suspend window and commits the tracker state at the
// accepting edge. A two-entry output buffer (output register plus skid slot)
// keeps the input ready while one result waits, so the input only stalls once
// two results are pending. A disconnect item (command set) clears the offsets
// and forces the next sample to seed the tracked position. Configuration
// writes are registered; write them only while no item is in flight. Writes
// to indexes beyond the register list are taken and ignored.
// ----------------------------------------------------------------------------
module odometry_wrap_reboot_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  odwr_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output odwr_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [odwr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [odwr_pkg::CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [odwr_pkg::CoordW-1:0]  coord_range_q, coord_thr_q, angle_range_q, angle_thr_q;
  logic [odwr_pkg::PeriodW-1:0] suspend_per_q;

  // tracker state
  logic [31:0] x_off_q, y_off_q, a_off_q;
  logic [31:0] x_off_d, y_off_d, a_off_d;
  logic [31:0] last_x_q, last_y_q, last_a_q;
  logic [31:0] last_x_d, last_y_d, last_a_d;
  logic [31:0] sus_start_q, sus_start_d;
  logic        known_q, known_d;
  logic        timer_q, timer_d;
  logic        sus_q, sus_d;
  logic        resume_q, resume_d;

  // output buffer
  logic                out_valid_q, skid_valid_q;
  odwr_pkg::out_item_t out_q, skid_q;
  odwr_pkg::out_item_t res;

  odwr_pkg::lane_res_t x_res, y_res, a_res;

  logic        push, pop;
  logic        expired, any_brk, resume_mid;
  logic [31:0] elapsed;

  assign cfg_ready_o = 1'b1;

  // Hold configuration; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_range_q <= odwr_pkg::CoordRangeRst;
      coord_thr_q   <= odwr_pkg::CoordThrRst;
      angle_range_q <= odwr_pkg::AngleRangeRst;
      angle_thr_q   <= odwr_pkg::AngleThrRst;
      suspend_per_q <= odwr_pkg::SuspendPerRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        odwr_pkg::REG_COORD_RANGE: coord_range_q <= cfg_data_i[odwr_pkg::CoordW-1:0];
        odwr_pkg::REG_COORD_THR:   coord_thr_q   <= cfg_data_i[odwr_pkg::CoordW-1:0];
        odwr_pkg::REG_ANGLE_RANGE: angle_range_q <= cfg_data_i[odwr_pkg::CoordW-1:0];
        odwr_pkg::REG_ANGLE_THR:   angle_thr_q   <= cfg_data_i[odwr_pkg::CoordW-1:0];
        odwr_pkg::REG_SUSPEND_PER: suspend_per_q <= cfg_data_i[odwr_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // Axis lanes
  odwr_lane u_lane_x (
    .raw_i  (in_data_i.raw_x),
    .off_i  (x_off_q),
    .last_i (last_x_q),
    .range_i(coord_range_q),
    .thr_i  (coord_thr_q),
    .res_o  (x_res)
  );

  odwr_lane u_lane_y (
    .raw_i  (in_data_i.raw_y),
    .off_i  (y_off_q),
    .last_i (last_y_q),
    .range_i(coord_range_q),
    .thr_i  (coord_thr_q),
    .res_o  (y_res)
  );

  odwr_lane u_lane_a (
    .raw_i  (in_data_i.raw_angle),
    .off_i  (a_off_q),
    .last_i (last_a_q),
    .range_i(angle_range_q),
    .thr_i  (angle_thr_q),
    .res_o  (a_res)
  );

  // Merge: suspend window and state commit
  assign elapsed    = in_data_i.time_ms - sus_start_q;
  assign expired    = !timer_q || (elapsed > suspend_per_q);
  assign any_brk    = x_res.brk || y_res.brk || a_res.brk;
  assign resume_mid = resume_q || expired;

  always_comb begin
    x_off_d     = x_off_q;
    y_off_d     = y_off_q;
    a_off_d     = a_off_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    last_a_d    = last_a_q;
    sus_start_d = sus_start_q;
    known_d     = known_q;
    timer_d     = timer_q;
    sus_d       = sus_q;
    resume_d    = resume_q;

    res.valid_res    = 1'b1;
    res.x_status     = odwr_pkg::ST_OK;
    res.y_status     = odwr_pkg::ST_OK;
    res.angle_status = odwr_pkg::ST_OK;

    if (in_data_i.command) begin
      known_d = 1'b0;
      x_off_d = 32'd0;
      y_off_d = 32'd0;
      a_off_d = 32'd0;
    end else if (known_q) begin
      // window expiry clears the suspend flag and re-arms resume
      if (expired && !resume_q) begin
        sus_d = 1'b0;
      end
      resume_d = resume_mid;
      x_off_d  = x_res.off;
      y_off_d  = y_res.off;
      a_off_d  = a_res.off;
      res.valid_res    = !any_brk;
      res.x_status     = x_res.status;
      res.y_status     = y_res.status;
      res.angle_status = a_res.status;
      if (any_brk) begin
        if (expired) begin
          sus_d = 1'b1;
        end
        sus_start_d = in_data_i.time_ms;
        timer_d     = 1'b1;
        resume_d    = 1'b0;
      end else if (resume_mid) begin
        // no lane broke, so every lane advances
        last_x_d = x_res.track;
        last_y_d = y_res.track;
        last_a_d = a_res.track;
      end
    end else begin
      last_x_d = {{16{in_data_i.raw_x[15]}}, in_data_i.raw_x};
      last_y_d = {{16{in_data_i.raw_y[15]}}, in_data_i.raw_y};
      last_a_d = {{16{in_data_i.raw_angle[15]}}, in_data_i.raw_angle};
      known_d  = 1'b1;
    end

    res.pos_x            = last_x_d;
    res.pos_y            = last_y_d;
    res.heading          = last_a_d;
    res.motion_suspended = sus_d;
  end

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  // Advance tracker state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q     <= '0;
      y_off_q     <= '0;
      a_off_q     <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_a_q    <= '0;
      sus_start_q <= '0;
      known_q     <= 1'b0;
      timer_q     <= 1'b0;
      sus_q       <= 1'b0;
      resume_q    <= 1'b0;
    end else if (push) begin
      x_off_q     <= x_off_d;
      y_off_q     <= y_off_d;
      a_off_q     <= a_off_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      last_a_q    <= last_a_d;
      sus_start_q <= sus_start_d;
      known_q     <= known_d;
      timer_q     <= timer_d;
      sus_q       <= sus_d;
      resume_q    <= resume_d;
    end
  end

  // Output register with skid slot: refill from skid first, else from the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res;
        end
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/odwr_checker.sv -----
// ----------------------------------------------------------------------------
// Odometry wrap tracker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module odwr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input odwr_pkg::out_item_t           out_data_o
);

  logic x_brk, y_brk, a_brk;

  assign x_brk = (out_data_o.x_status == odwr_pkg::ST_REBOOT) ||
                 (out_data_o.x_status == odwr_pkg::ST_CRASH);
  assign y_brk = (out_data_o.y_status == odwr_pkg::ST_REBOOT) ||
                 (out_data_o.y_status == odwr_pkg::ST_CRASH);
  assign a_brk = (out_data_o.angle_status == odwr_pkg::ST_REBOOT) ||
                 (out_data_o.angle_status == odwr_pkg::ST_CRASH);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // valid_res drops exactly when some axis broke
  a_valid_brk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.valid_res == !(x_brk || y_brk || a_brk)))
    else $error("valid_res disagrees with axis status");

  // input stalls only with a result pending
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // no result appears without an accepted item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result appeared from nothing");

endmodule

bind odometry_wrap_reboot_tracker odwr_checker u_odwr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ----- tb/odometry_wrap_reboot_tracker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry wrap and reboot tracker testbench
// Drives odometry samples and disconnects through the valid/ready input,
// predicts every tracked result with a cycle-free model of the unwrapping
// rules and compares each result field by field, across several register
// settings including the extremes, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module odometry_wrap_reboot_tracker_test;

  localparam logic                         CmdSample     = 1'b0;
  localparam logic                         CmdDisconnect = 1'b1;
  // Index past the register list: the block takes the write and drops it
  localparam logic [odwr_pkg::CfgIdxW-1:0] RegSpare      = 3'd7;
  localparam int                           NumPhases     = 7;
  localparam int                           CycleLimit    = 500_000;

  // One row of the directed table; gold is only meaningful when known is set
  typedef struct packed {
    odwr_pkg::in_item_t  stim;
    logic                known;
    odwr_pkg::out_item_t gold;
  } vector_t;

  // One register setting, as the stimulus generator sees it
  typedef struct {
    int          coord_span;
    int          coord_thr;
    int          hdg_span;
    int          hdg_thr;
    logic [31:0] hold_ms;
  } setting_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  odwr_pkg::in_item_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  odwr_pkg::out_item_t           out_data_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [odwr_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [odwr_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  // Typed-in expectation travelling alongside the item on the input channel
  logic                gold_known  = 1'b0;
  odwr_pkg::out_item_t gold_fix    = '0;

  // Tracker model: registers
  logic [19:0] cfg_coord_span, cfg_coord_thr, cfg_hdg_span, cfg_hdg_thr;
  logic [31:0] cfg_hold_ms;
  // Tracker model: state
  logic [31:0] x_bias, y_bias, hdg_bias;
  logic [31:0] x_trk, y_trk, hdg_trk;
  logic [31:0] hold_t0;
  logic        seeded, hold_armed, frozen, resumed;

  odwr_pkg::out_item_t fix_queue[$];   // tracked results still owed by the block
  int          items_out   = 0;
  int          fixes_seen  = 0;
  int          mismatches  = 0;
  int          cycles      = 0;

  // Stimulus side: the simulated device counters and the sample clock
  setting_t    cur;
  int          dev_x, dev_y, dev_hdg;
  logic [31:0] clock_ms, break_ms;
  bit          in_steady = 1'b0;

  vector_t     dir_table[$];

  odometry_wrap_reboot_tracker i_dut (.*);

  always #1 clk_i = ~clk_i;

  // Give up on a hang rather than spin forever
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("odometry_wrap_reboot_tracker_test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tracker model
  // --------------------------------------------------------------------------
  function automatic void reset_tracker();
    cfg_coord_span = odwr_pkg::CoordRangeRst;
    cfg_coord_thr  = odwr_pkg::CoordThrRst;
    cfg_hdg_span   = odwr_pkg::AngleRangeRst;
    cfg_hdg_thr    = odwr_pkg::AngleThrRst;
    cfg_hold_ms    = odwr_pkg::SuspendPerRst;
    x_bias = '0; y_bias = '0; hdg_bias = '0;
    x_trk  = '0; y_trk  = '0; hdg_trk  = '0;
    hold_t0 = '0;
    seeded = 1'b0; hold_armed = 1'b0; frozen = 1'b0; resumed = 1'b0;
  endfunction

  function automatic void apply_reg(logic [odwr_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    case (idx)
      odwr_pkg::REG_COORD_RANGE: cfg_coord_span = data[19:0];
      odwr_pkg::REG_COORD_THR:   cfg_coord_thr  = data[19:0];
      odwr_pkg::REG_ANGLE_RANGE: cfg_hdg_span   = data[19:0];
      odwr_pkg::REG_ANGLE_THR:   cfg_hdg_thr    = data[19:0];
      odwr_pkg::REG_SUSPEND_PER: cfg_hold_ms    = data;
      default: ;
    endcase
  endfunction

  // Magnitude of a wrapped 32-bit difference; the most negative value is 2^31
  function automatic longint magnitude(logic [31:0] v);
    logic [31:0] neg;
    neg = -v;
    return v[31] ? longint'(neg) : longint'(v);
  endfunction

  // Classify one axis and move its bias: wrap, reboot/crash re-base, else
  // ok or uncertain when the tracked value sits near zero
  function automatic odwr_pkg::status_e classify_axis(input logic [31:0] raw,
                                                      inout logic [31:0] bias,
                                                      input logic [31:0] prev,
                                                      input logic [19:0] span,
                                                      input logic [19:0] thr);
    logic [31:0] delta;
    longint      jump, twice, lim;
    delta = raw + bias - prev;
    jump  = magnitude(delta);
    twice = 2 * longint'(span);
    lim   = longint'(thr);
    if (jump > lim) begin
      if (jump <= twice + lim && jump >= twice - lim) begin
        bias = delta[31] ? bias + 32'(twice) : bias - 32'(twice);
        return odwr_pkg::ST_WRAP;
      end
      bias = prev - raw;
      return (magnitude(raw) <= lim) ? odwr_pkg::ST_REBOOT : odwr_pkg::ST_CRASH;
    end
    return (magnitude(prev + bias) < lim) ? odwr_pkg::ST_UNCERTAIN : odwr_pkg::ST_OK;
  endfunction

  function automatic logic breaks_lock(odwr_pkg::status_e s);
    return s == odwr_pkg::ST_REBOOT || s == odwr_pkg::ST_CRASH;
  endfunction

  function automatic odwr_pkg::out_item_t unwrap_sample(odwr_pkg::in_item_t it);
    odwr_pkg::out_item_t r;
    odwr_pkg::status_e   sx, sy, sa;
    logic                intact, lapsed;
    logic [31:0]         rx, ry, ra, elapsed;
    sx = odwr_pkg::ST_OK; sy = odwr_pkg::ST_OK; sa = odwr_pkg::ST_OK;
    intact = 1'b1;
    rx = {{16{it.raw_x[15]}}, it.raw_x};
    ry = {{16{it.raw_y[15]}}, it.raw_y};
    ra = {{16{it.raw_angle[15]}}, it.raw_angle};
    if (it.command == CmdDisconnect) begin
      seeded = 1'b0;
      x_bias = '0; y_bias = '0; hdg_bias = '0;
    end else if (seeded) begin
      elapsed = it.time_ms - hold_t0;
      lapsed  = !hold_armed || elapsed > cfg_hold_ms;
      if (lapsed && !resumed) begin
        frozen  = 1'b0;
        resumed = 1'b1;
      end
      sx = classify_axis(rx, x_bias, x_trk, cfg_coord_span, cfg_coord_thr);
      sy = classify_axis(ry, y_bias, y_trk, cfg_coord_span, cfg_coord_thr);
      sa = classify_axis(ra, hdg_bias, hdg_trk, cfg_hdg_span, cfg_hdg_thr);
      intact = !(breaks_lock(sx) || breaks_lock(sy) || breaks_lock(sa));
      if (!intact) begin
        // Reboot or crash: (re)open the suspend window
        if (lapsed && resumed) frozen = 1'b1;
        hold_t0    = it.time_ms;
        hold_armed = 1'b1;
        resumed    = 1'b0;
      end
      if (!breaks_lock(sx) && resumed) x_trk   = rx + x_bias;
      if (!breaks_lock(sy) && resumed) y_trk   = ry + y_bias;
      if (!breaks_lock(sa) && resumed) hdg_trk = ra + hdg_bias;
    end else begin
      x_trk   = rx;
      y_trk   = ry;
      hdg_trk = ra;
      seeded  = 1'b1;
    end
    r.pos_x            = x_trk;
    r.pos_y            = y_trk;
    r.heading          = hdg_trk;
    r.valid_res        = intact;
    r.x_status         = sx;
    r.y_status         = sy;
    r.angle_status     = sa;
    r.motion_suspended = frozen;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted item, compare on every accepted result.
  // Everything is sampled at the rising edge, before that edge's updates land.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    odwr_pkg::out_item_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        // Always advance the model; a typed-in row overrides its prediction
        want = unwrap_sample(in_data_i);
        fix_queue.push_back(gold_known ? gold_fix : want);
      end
      if (out_valid_o && out_ready_i) begin
        fixes_seen++;
        if (fix_queue.size() == 0) begin
          $error("result arrived with nothing outstanding");
          mismatches++;
        end else begin
          want = fix_queue.pop_front();
          check_field("pos_x", want.pos_x, out_data_o.pos_x);
          check_field("pos_y", want.pos_y, out_data_o.pos_y);
          check_field("heading", want.heading, out_data_o.heading);
          check_field("valid_res", int'(want.valid_res), int'(out_data_o.valid_res));
          check_field("x_status", int'(want.x_status), int'(out_data_o.x_status));
          check_field("y_status", int'(want.y_status), int'(out_data_o.y_status));
          check_field("angle_status", int'(want.angle_status),
                      int'(out_data_o.angle_status));
          check_field("motion_suspended", int'(want.motion_suspended),
                      int'(out_data_o.motion_suspended));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: drop ready for a random stall before each result, with
  // stretches of no stalling at all
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic vector_t row(logic cmd, int x, int y, int a, logic [31:0] t);
    vector_t v;
    v.stim.command   = cmd;
    v.stim.raw_x     = 16'(x);
    v.stim.raw_y     = 16'(y);
    v.stim.raw_angle = 16'(a);
    v.stim.time_ms   = t;
    v.known          = 1'b0;
    v.gold           = '0;
    return v;
  endfunction

  function automatic vector_t row_gold(logic cmd, int x, int y, int a, logic [31:0] t,
                                       odwr_pkg::out_item_t g);
    vector_t v;
    v       = row(cmd, x, y, a, t);
    v.known = 1'b1;
    v.gold  = g;
    return v;
  endfunction

  // After an optional random gap, hold valid high, unchanged, until the block takes the item
  task automatic send_item(input odwr_pkg::in_item_t it, input logic known,
                           input odwr_pkg::out_item_t gold);
    int gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    gold_known <= known;
    gold_fix   <= gold;
    do @(posedge clk_i); while (!in_ready_o);
    items_out++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (fixes_seen != items_out) @(posedge clk_i);
  endtask

  // Write all five registers and the spare index back to back; stray upper
  // bits on the 20-bit registers must be dropped by the block
  task automatic program_regs(input setting_t s);
    logic [odwr_pkg::CfgIdxW-1:0] idx[6];
    logic [31:0]                  val[6];
    idx = '{odwr_pkg::REG_COORD_RANGE, odwr_pkg::REG_COORD_THR, odwr_pkg::REG_ANGLE_RANGE,
            odwr_pkg::REG_ANGLE_THR, RegSpare, odwr_pkg::REG_SUSPEND_PER};
    val = '{{12'($urandom), 20'(s.coord_span)}, {12'($urandom), 20'(s.coord_thr)},
            {12'($urandom), 20'(s.hdg_span)}, {12'($urandom), 20'(s.hdg_thr)},
            $urandom, s.hold_ms};
    for (int k = 0; k < 6; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Move a device counter by a small step, wrapping at its half span the way
  // the real counter does, and clamp into the 16-bit reading
  function automatic int wander(int pos, int span, int stride);
    int p;
    p = pos + int'($urandom_range(0, 2 * stride)) - stride;
    if (p > span) p -= 2 * span;
    else if (p < -span) p += 2 * span;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p;
  endfunction

  function automatic int near_zero(int thr);
    int reach;
    reach = (thr > 300) ? 300 : thr;
    return int'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  // Mostly smooth motion with wraps; then reboots, crashes, disconnects,
  // probes of the suspend window edge and plain noise
  function automatic odwr_pkg::in_item_t draw_sample();
    odwr_pkg::in_item_t it;
    int                 pick, cstride, hstride;
    cstride = (cur.coord_thr > 4000) ? 4000 : ((cur.coord_thr < 1) ? 1 : cur.coord_thr);
    hstride = (cur.hdg_thr > 4000) ? 4000 : ((cur.hdg_thr < 1) ? 1 : cur.hdg_thr);
    pick = $urandom_range(0, 99);
    it.command = CmdSample;
    clock_ms += $urandom_range(0, 250);
    if (pick < 72 || (pick >= 88 && pick < 93)) begin
      if (pick >= 88) clock_ms = break_ms + cur.hold_ms + $urandom_range(0, 1);
      dev_x   = wander(dev_x, cur.coord_span, cstride);
      dev_y   = wander(dev_y, cur.coord_span, cstride);
      dev_hdg = wander(dev_hdg, cur.hdg_span, hstride);
    end else if (pick < 80) begin
      // Controller reboot: some counters restart close to zero
      dev_x   = $urandom_range(0, 1) ? near_zero(cur.coord_thr) : dev_x;
      dev_y   = $urandom_range(0, 1) ? near_zero(cur.coord_thr) : dev_y;
      dev_hdg = $urandom_range(0, 1) ? near_zero(cur.hdg_thr) : dev_hdg;
      break_ms = clock_ms;
    end else if (pick < 85) begin
      case ($urandom_range(0, 2))
        0: dev_x = int'($urandom_range(0, 65535)) - 32768;
        1: dev_y = int'($urandom_range(0, 65535)) - 32768;
        default: dev_hdg = int'($urandom_range(0, 65535)) - 32768;
      endcase
      break_ms = clock_ms;
    end else if (pick >= 93) begin
      dev_x   = int'($urandom_range(0, 65535)) - 32768;
      dev_y   = int'($urandom_range(0, 65535)) - 32768;
      dev_hdg = int'($urandom_range(0, 65535)) - 32768;
      clock_ms   = $urandom;
      it.command = 1'($urandom_range(0, 1));
    end
    it.raw_x     = 16'(dev_x);
    it.raw_y     = 16'(dev_y);
    it.raw_angle = 16'(dev_hdg);
    it.time_ms   = clock_ms;
    if (pick >= 85 && pick < 88) begin
      // Disconnect: the readings it carries are meaningless, so scramble them
      it.command   = CmdDisconnect;
      it.raw_x     = 16'($urandom);
      it.raw_y     = 16'($urandom);
      it.raw_angle = 16'($urandom);
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      // Once per batch, pause the sender until everything has come back
      if (k == count / 2) hold_until_drained();
      send_item(draw_sample(), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    // Directed rows at the reset settings (ranges 32000 and 31415, thresholds
    // 1000 and 785, window 1000 ms). Typed expectations cover the seeding
    // sample, the uncertain near-zero case and the first crash.
    dir_table = '{
      row_gold(CmdSample, 100, -200, 50, 32'd0,
               '{32'sd100, -32'sd200, 32'sd50, 1'b1,
                 odwr_pkg::ST_OK, odwr_pkg::ST_OK, odwr_pkg::ST_OK, 1'b0}),
      row_gold(CmdSample, 150, -180, 60, 32'd10,
               '{32'sd150, -32'sd180, 32'sd60, 1'b1,
                 odwr_pkg::ST_UNCERTAIN, odwr_pkg::ST_UNCERTAIN, odwr_pkg::ST_UNCERTAIN,
                 1'b0}),
      row_gold(CmdSample, 32767, -180, 60, 32'd20,
               '{32'sd150, -32'sd180, 32'sd60, 1'b0,
                 odwr_pkg::ST_CRASH, odwr_pkg::ST_UNCERTAIN, odwr_pkg::ST_UNCERTAIN,
                 1'b1}),
      row(CmdSample, 32767, -180, 60, 32'd500),          // inside the window: hold
      row(CmdSample, 32767, -180, 60, 32'd1021),         // window over: resume
      row(CmdSample, 31900, -900, 700, 32'd1200),
      row(CmdSample, -31900, -1800, 1400, 32'd1300),     // x counter wraps
      row(CmdSample, -31800, -1800, 5, 32'd1500),        // heading reboot
      row(CmdDisconnect, -32768, -32768, -32768, 32'd1600),
      row(CmdSample, -32768, 32767, -32768, 32'hFFFF_FF00),
      row(CmdSample, -32768, 32767, -32768, 32'hFFFF_FFFF),
      row(CmdSample, 32767, 32767, -32768, 32'h0000_0010), // clock wraps, x crash
      row(CmdSample, 32767, 32767, -32768, 32'h0000_0020),
      row(CmdSample, 32767, 32767, -32768, 32'd1016),    // exactly one period: hold
      row(CmdSample, 32767, 32767, -32768, 32'd1017),    // one past: resume
      row(CmdSample, 0, 0, 0, 32'd1100),                 // all axes reboot
      row(CmdDisconnect, 32767, 32767, 32767, 32'hFFFF_FFFF),
      row(CmdDisconnect, 0, 0, 0, 32'd0),
      row(CmdSample, 0, 0, 0, 32'd0),
      row(CmdSample, 0, 0, 0, 32'd5)
    };

    reset_tracker();
    cur = '{int'(odwr_pkg::CoordRangeRst), int'(odwr_pkg::CoordThrRst),
            int'(odwr_pkg::AngleRangeRst), int'(odwr_pkg::AngleThrRst),
            odwr_pkg::SuspendPerRst};
    dev_x = 0; dev_y = 0; dev_hdg = 0;
    clock_ms = 32'd0;
    break_ms = 32'd0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      send_item(dir_table[i].stim, dir_table[i].known, dir_table[i].gold);
    end
    run_random(240);

    for (int p = 0; p < NumPhases; p++) begin
      hold_until_drained();
      case (p)
        0: cur = '{1, 0, 1, 0, 32'd0};
        1: cur = '{1000000, 1000000, 1000000, 1000000, 32'hFFFF_FFFF};
        2: cur = '{32767, 2000, 32767, 1500, 32'd3000};
        default: cur = '{int'($urandom_range(500, 32767)), int'($urandom_range(0, 3000)),
                         int'($urandom_range(500, 32767)), int'($urandom_range(0, 3000)),
                         32'($urandom_range(0, 3000))};
      endcase
      // Start the first two settings from a fresh, quiet device position
      if (p == 0 || p == 1) begin
        dev_x = 0; dev_y = 0; dev_hdg = 0;
      end
      program_regs(cur);
      run_random((p < 2) ? 150 : 260);
    end

    hold_until_drained();
    // Allow for the output register and skid slot to flush any stray result
    repeat (8) @(posedge clk_i);
    if (fix_queue.size() != 0) begin
      $error("%0d results never arrived", fix_queue.size());
      mismatches++;
    end
    if (mismatches == 0) $display("odometry_wrap_reboot_tracker_test passed");
    else $display("odometry_wrap_reboot_tracker_test failed");
    $finish;
  end

endmodule
